>>> hw/rtl/trz_pkg.sv
// Shared types and fixed constants for the triangle rasterizer core.
// No dependencies; imported by the channel interface users and the top level.
`timescale 1ns / 1ps
`default_nettype none
package trz_pkg;

    // Operation codes carried in the func field of an input word
    localparam logic [1:0] FUNC_DRAW_SOLID = 2'd0;
    localparam logic [1:0] FUNC_DRAW_BARY  = 2'd1;
    localparam logic [1:0] FUNC_READ       = 2'd2;
    localparam logic [1:0] FUNC_CLEAR      = 2'd3;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_CLEAR_COLOR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLEAR_DEPTH = 1'd1;

    // Register reset values
    localparam logic [31:0] CLEAR_COLOR_RST = 32'hFF7D007D;
    localparam logic [15:0] CLEAR_DEPTH_RST = 16'hFFFF;

    // Color constants
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // Datapath widths (fixed by the field widths and the parameter ranges)
    localparam int EW  = 24;        // edge operand, signed
    localparam int PW  = 2 * EW;    // edge product
    localparam int WW  = PW + 1;    // edge function value
    localparam int AAW = 30;        // |area|, vertex coordinates only
    localparam int BW  = 17;        // barycentric, 0..65536
    localparam int QW  = 49;        // divider quotient
    localparam int DVW = 66;        // divider remainder and divisor
    localparam int SW  = 51;        // depth sum
    localparam int CW  = 14;        // pixel coordinate
    localparam int CNTW = 17;       // pixels written counter

    localparam logic [BW-1:0] BARY_ONE = 17'd65536;

    typedef struct packed {
        logic [1:0]  func;
        logic [12:0] ax;
        logic [12:0] ay;
        logic [15:0] az;
        logic [12:0] bx;
        logic [12:0] by;
        logic [15:0] bz;
        logic [12:0] cx;
        logic [12:0] cy;
        logic [15:0] cz;
        logic [31:0] solid_color;
        logic [15:0] pixel_index;
    } t_in_word;

    typedef struct packed {
        logic [31:0] pixel_color;
        logic [15:0] pixel_depth;
        logic [16:0] pixels_written;
        logic        status;
    } t_out_word;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [31:0]          value;
    } t_cfg_word;

endpackage
`default_nettype wire

>>> hw/rtl/trz_chan_if.sv
// Valid/ready channel carrying one word of a given payload type.
// Depends on trz_pkg for the payload types used at instantiation.
`timescale 1ns / 1ps
`default_nettype none
interface trz_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/triangle_rasterizer_zbuffer_core.sv
// Triangle rasterizer with color and depth stores, top level.
// Depends on trz_pkg and trz_chan_if.
//
// Usage: words arrive on i_in (valid/ready), results leave on o_out, one
// result word per input word, in order. i_cfg writes clear_color (index 0)
// and clear_depth (index 1); it is always ready. It must be written only
// while idle; the core does not enforce this. A clear word sweeps both
// stores, one pixel per cycle; a read word reads both stores. A draw word
// runs an area setup and a finish state, and per bounding box pixel the
// edge functions, the coverage test and the step and, for a covered pixel,
// the divisions: one shared restoring divider retires one quotient bit a
// cycle (three 17 bit, three 49 bit and, unless the depth saturates, one 16
// bit division, each with a closing state), then the depth test and write.
// One word is worked at a time; i_in.ready is high while the core is idle,
// also while a finished result waits on o_out. A stalled receiver holds the
// next result until the previous one is taken. Reset clears control state
// and the configuration registers; the stores stay undefined until a clear.
`timescale 1ns / 1ps
`default_nettype none
module triangle_rasterizer_zbuffer_core #(
    parameter int FB_WIDTH      = 256,
    parameter int FB_HEIGHT     = 256,
    parameter int SUBPIXEL_BITS = 4
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    trz_chan_if.sink   i_in,
    trz_chan_if.source o_out,
    trz_chan_if.sink   i_cfg
);
    import trz_pkg::*;

    localparam int PIX = FB_WIDTH * FB_HEIGHT;
    localparam int AW  = $clog2(PIX);
    localparam int LW  = AW + CW;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_AMUL = 5'd1;
    localparam logic [4:0] S_ASUB = 5'd2;
    localparam logic [4:0] S_EMUL = 5'd3;
    localparam logic [4:0] S_ESUB = 5'd4;
    localparam logic [4:0] S_TEST = 5'd5;
    localparam logic [4:0] S_BDIV = 5'd6;
    localparam logic [4:0] S_BEND = 5'd7;
    localparam logic [4:0] S_TDIV = 5'd8;
    localparam logic [4:0] S_TEND = 5'd9;
    localparam logic [4:0] S_FDIV = 5'd10;
    localparam logic [4:0] S_FEND = 5'd11;
    localparam logic [4:0] S_CMP  = 5'd12;
    localparam logic [4:0] S_NEXT = 5'd13;
    localparam logic [4:0] S_CLR  = 5'd14;
    localparam logic [4:0] S_FIN  = 5'd15;

    localparam logic [1:0] VA = 2'd0;
    localparam logic [1:0] VB = 2'd1;
    localparam logic [1:0] VC = 2'd2;

    localparam logic [SW-1:0] SUM_SAT = SW'(64'h1_0000_0000);

    // control and working registers
    logic [4:0]  r_state;
    logic [1:0]  r_func;
    logic [1:0]  r_k;
    logic        r_bary;
    logic [31:0] r_solid;
    logic signed [EW-1:0] r_vx [3];
    logic signed [EW-1:0] r_vy [3];
    logic [15:0] r_vz [3];
    logic [CW-1:0] r_minx, r_miny, r_maxx, r_maxy, r_i, r_j;
    logic signed [PW-1:0] r_pa, r_pb;
    logic signed [WW-1:0] r_w [3];
    logic [AAW-1:0] r_aabs;
    logic        r_empty;
    logic [AW-1:0] r_idx;
    logic [AW-1:0] r_addr;
    logic        r_oob;
    logic [BW-1:0] r_bc [3];
    logic [SW-1:0] r_s;
    logic [15:0] r_z;
    logic [CNTW-1:0] r_count;
    logic        r_status;
    logic [DVW-1:0] r_rem, r_dsh;
    logic [QW-1:0]  r_q;
    logic [5:0]  r_dcnt;
    logic [31:0] r_clear_color;
    logic [15:0] r_clear_depth;
    logic [31:0] r_rd_col;
    logic [15:0] r_rd_dep;
    logic        r_out_valid;
    t_out_word   r_out;

    logic [31:0] m_color [PIX];
    logic [15:0] m_depth [PIX];

    // memory port controls
    logic        mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [31:0] mem_wcol;
    logic [15:0] mem_wdep;

    t_in_word w_in;
    assign w_in = i_in.data;
    logic w_acc;
    assign w_acc = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // bounding box of the incoming triangle, clamped on the far side
    logic [12:0] w_mnx, w_mny, w_mxx, w_mxy;
    logic [CW-1:0] w_bminx, w_bminy, w_bmaxx, w_bmaxy;
    always_comb begin
        w_mnx = (w_in.ax < w_in.bx) ? w_in.ax : w_in.bx;
        w_mnx = (w_mnx < w_in.cx) ? w_mnx : w_in.cx;
        w_mny = (w_in.ay < w_in.by) ? w_in.ay : w_in.by;
        w_mny = (w_mny < w_in.cy) ? w_mny : w_in.cy;
        w_mxx = (w_in.ax > w_in.bx) ? w_in.ax : w_in.bx;
        w_mxx = (w_mxx > w_in.cx) ? w_mxx : w_in.cx;
        w_mxy = (w_in.ay > w_in.by) ? w_in.ay : w_in.by;
        w_mxy = (w_mxy > w_in.cy) ? w_mxy : w_in.cy;
        w_bminx = CW'(w_mnx >> SUBPIXEL_BITS);
        w_bminy = CW'(w_mny >> SUBPIXEL_BITS);
        w_bmaxx = CW'(w_mxx >> SUBPIXEL_BITS);
        w_bmaxy = CW'(w_mxy >> SUBPIXEL_BITS);
        if (w_bmaxx > CW'(FB_WIDTH - 1)) begin
            w_bmaxx = CW'(FB_WIDTH - 1);
        end
        if (w_bmaxy > CW'(FB_HEIGHT - 1)) begin
            w_bmaxy = CW'(FB_HEIGHT - 1);
        end
    end

    // edge function operands: pick vertices for edge r_k and the sample point
    logic signed [EW-1:0] w_px, w_py, w_ptx, w_pty;
    logic signed [EW-1:0] w_ex_b, w_ey_b, w_ex_a, w_ey_a;
    logic signed [PW-1:0] w_pa, w_pb;
    logic [1:0] w_bi, w_ai;
    always_comb begin
        unique case (r_k)
            2'd0: begin w_bi = VC; w_ai = VB; end
            2'd1: begin w_bi = VA; w_ai = VC; end
            2'd2: begin w_bi = VB; w_ai = VA; end
            default: begin w_bi = VB; w_ai = VA; end
        endcase
        w_px = signed'(EW'({r_i, 1'b1}) << SUBPIXEL_BITS);
        w_py = signed'(EW'({r_j, 1'b1}) << SUBPIXEL_BITS);
        w_ptx = (r_state == S_AMUL) ? r_vx[VC] : w_px;
        w_pty = (r_state == S_AMUL) ? r_vy[VC] : w_py;
        w_ex_b = r_vx[w_bi];
        w_ey_b = r_vy[w_bi];
        w_ex_a = r_vx[w_ai];
        w_ey_a = r_vy[w_ai];
        w_pa = PW'(w_ptx - w_ex_a) * PW'(w_ey_b - w_ey_a);
        w_pb = PW'(w_pty - w_ey_a) * PW'(w_ex_b - w_ex_a);
    end

    logic signed [WW-1:0] w_edge;
    assign w_edge = WW'(r_pa) - WW'(r_pb);

    // pixel address and coverage
    logic [LW-1:0] w_lin;
    assign w_lin = LW'(r_j) * LW'(FB_WIDTH) + LW'(r_i);
    logic w_inside;
    assign w_inside = (!r_w[0][WW-1] && !r_w[1][WW-1] && !r_w[2][WW-1])
        || ((r_w[0][WW-1] || r_w[0] == '0) && (r_w[1][WW-1] || r_w[1] == '0)
            && (r_w[2][WW-1] || r_w[2] == '0));

    // restoring divider step
    logic w_ge;
    assign w_ge = (r_rem >= r_dsh);

    // divider operands for the barycentric of lane w_kn
    logic [1:0] w_kn;
    assign w_kn = (r_state == S_TEST) ? 2'd0 : r_k + 2'd1;
    logic signed [WW-1:0] w_wsel;
    logic [WW-1:0] w_wabs;
    assign w_wsel = r_w[w_kn];
    assign w_wabs = w_wsel[WW-1] ? WW'(-w_wsel) : WW'(w_wsel);

    // barycentric clamp and depth sum update
    logic [BW-1:0] w_bcq;
    assign w_bcq = (r_q > QW'(BARY_ONE)) ? BARY_ONE : BW'(r_q);
    logic [SW-1:0] w_snew;
    assign w_snew = r_s + SW'(r_q);

    // barycentric color channels, (bc*255)>>16
    logic [BW+7:0] w_sc [3];
    logic [31:0] w_color;
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_sc[c] = {r_bc[c], 8'd0} - (BW+8)'(r_bc[c]);
        end
        w_color = r_bary ? {ALPHA_OPAQUE, w_sc[0][23:16], w_sc[1][23:16], w_sc[2][23:16]}
                         : r_solid;
    end

    // result fields picked by the finished word's function
    logic w_fin_read, w_fin_draw;
    assign w_fin_read = (r_func == FUNC_READ) && !r_oob;
    assign w_fin_draw = (r_func == FUNC_DRAW_SOLID) || (r_func == FUNC_DRAW_BARY);

    // finish step fires once the output register is free
    logic w_fin_go;
    assign w_fin_go = (r_state == S_FIN) && (!r_out_valid || o_out.ready);

    // memory port selection
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wcol  = w_color;
        mem_wdep  = r_z;
        mem_re    = 1'b0;
        mem_raddr = AW'(w_lin);
        if (r_state == S_CLR) begin
            mem_we    = 1'b1;
            mem_waddr = r_addr;
            mem_wcol  = r_clear_color;
            mem_wdep  = r_clear_depth;
        end else if (r_state == S_CMP && r_z < r_rd_dep) begin
            mem_we = 1'b1;
        end
        if (r_state == S_TEST && w_inside) begin
            mem_re = 1'b1;
        end else if (w_acc && w_in.func == FUNC_READ) begin
            mem_re    = 1'b1;
            mem_raddr = AW'(w_in.pixel_index);
        end
    end

    // store write and registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            m_color[mem_waddr] <= mem_wcol;
            m_depth[mem_waddr] <= mem_wdep;
        end
        if (mem_re) begin
            r_rd_col <= m_color[mem_raddr];
            r_rd_dep <= m_depth[mem_raddr];
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clear_color <= CLEAR_COLOR_RST;
            r_clear_depth <= CLEAR_DEPTH_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.index)
                REG_CLEAR_COLOR: r_clear_color <= i_cfg.data.value;
                REG_CLEAR_DEPTH: r_clear_depth <= i_cfg.data.value[15:0];
                default: ;
            endcase
        end
    end

    // result valid: raise out of the finish state, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fin_go) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_func   <= w_in.func;
                        r_bary   <= (w_in.func == FUNC_DRAW_BARY);
                        r_solid  <= w_in.solid_color;
                        r_vx[VA] <= EW'({w_in.ax, 1'b0});
                        r_vy[VA] <= EW'({w_in.ay, 1'b0});
                        r_vx[VB] <= EW'({w_in.bx, 1'b0});
                        r_vy[VB] <= EW'({w_in.by, 1'b0});
                        r_vx[VC] <= EW'({w_in.cx, 1'b0});
                        r_vy[VC] <= EW'({w_in.cy, 1'b0});
                        r_vz[VA] <= (w_in.az == '0) ? 16'd1 : w_in.az;
                        r_vz[VB] <= (w_in.bz == '0) ? 16'd1 : w_in.bz;
                        r_vz[VC] <= (w_in.cz == '0) ? 16'd1 : w_in.cz;
                        r_minx   <= w_bminx;
                        r_miny   <= w_bminy;
                        r_maxx   <= w_bmaxx;
                        r_maxy   <= w_bmaxy;
                        r_empty  <= (w_bminx > w_bmaxx) || (w_bminy > w_bmaxy);
                        r_oob    <= (32'(w_in.pixel_index) >= 32'(PIX));
                        r_k      <= 2'd2;
                        r_count  <= '0;
                        r_status <= 1'b0;
                        r_addr   <= '0;
                        unique case (w_in.func)
                            FUNC_DRAW_SOLID, FUNC_DRAW_BARY: r_state <= S_AMUL;
                            FUNC_READ:                       r_state <= S_FIN;
                            FUNC_CLEAR:                      r_state <= S_CLR;
                            default:                         r_state <= S_FIN;
                        endcase
                    end
                end
                S_AMUL, S_EMUL: begin
                    r_pa    <= w_pa;
                    r_pb    <= w_pb;
                    r_state <= (r_state == S_AMUL) ? S_ASUB : S_ESUB;
                end
                S_ASUB: begin
                    r_aabs <= w_edge[WW-1] ? AAW'(-w_edge) : AAW'(w_edge);
                    r_i    <= r_minx;
                    r_j    <= r_miny;
                    r_k    <= 2'd0;
                    if (w_edge == '0) begin
                        r_status <= 1'b1;
                        r_state  <= S_FIN;
                    end else if (r_empty) begin
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_EMUL;
                    end
                end
                S_ESUB: begin
                    r_w[r_k] <= w_edge;
                    if (r_k == 2'd2) begin
                        r_state <= S_TEST;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= S_EMUL;
                    end
                end
                S_TEST: begin
                    r_idx <= AW'(w_lin);
                    r_s   <= '0;
                    r_k   <= 2'd0;
                    if (w_inside) begin
                        r_rem   <= DVW'(w_wabs) << 16;
                        r_dsh   <= DVW'(r_aabs) << 16;
                        r_q     <= '0;
                        r_dcnt  <= 6'd16;
                        r_state <= S_BDIV;
                    end else begin
                        r_state <= S_NEXT;
                    end
                end
                S_BDIV, S_TDIV, S_FDIV: begin
                    if (w_ge) begin
                        r_rem <= r_rem - r_dsh;
                    end
                    r_dsh  <= r_dsh >> 1;
                    r_q    <= {r_q[QW-2:0], w_ge};
                    r_dcnt <= r_dcnt - 6'd1;
                    if (r_dcnt == '0) begin
                        r_state <= (r_state == S_BDIV) ? S_BEND
                                 : (r_state == S_TDIV) ? S_TEND : S_FEND;
                    end
                end
                S_BEND: begin
                    r_bc[r_k] <= w_bcq;
                    r_rem     <= DVW'(w_bcq) << 32;
                    r_dsh     <= DVW'(r_vz[r_k]) << 48;
                    r_q       <= '0;
                    r_dcnt    <= 6'd48;
                    r_state   <= S_TDIV;
                end
                S_TEND: begin
                    r_s <= w_snew;
                    r_q <= '0;
                    if (r_k == 2'd2) begin
                        if (w_snew <= SUM_SAT) begin
                            r_z     <= 16'hFFFF;
                            r_state <= S_CMP;
                        end else begin
                            r_rem   <= DVW'(1) << 48;
                            r_dsh   <= DVW'(w_snew) << 15;
                            r_dcnt  <= 6'd15;
                            r_state <= S_FDIV;
                        end
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_rem   <= DVW'(w_wabs) << 16;
                        r_dsh   <= DVW'(r_aabs) << 16;
                        r_dcnt  <= 6'd16;
                        r_state <= S_BDIV;
                    end
                end
                S_FEND: begin
                    r_z     <= r_q[15:0];
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (mem_we && r_count != '1) begin
                        r_count <= r_count + CNTW'(1);
                    end
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    r_k <= 2'd0;
                    if (r_i == r_maxx) begin
                        r_i <= r_minx;
                        if (r_j == r_maxy) begin
                            r_state <= S_FIN;
                        end else begin
                            r_j     <= r_j + CW'(1);
                            r_state <= S_EMUL;
                        end
                    end else begin
                        r_i     <= r_i + CW'(1);
                        r_state <= S_EMUL;
                    end
                end
                S_CLR: begin
                    r_addr <= r_addr + AW'(1);
                    if (r_addr == AW'(PIX - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    // hold until the output register is free
                    if (w_fin_go) begin
                        r_out <= '{
                            pixel_color:    w_fin_read ? r_rd_col : 32'd0,
                            pixel_depth:    w_fin_read ? r_rd_dep : 16'd0,
                            pixels_written: w_fin_draw ? r_count : CNTW'(0),
                            status:         w_fin_draw && r_status
                        };
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // stores are written only by the depth test or the clear sweep
    a_we_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_CMP || r_state == S_CLR))
        else $error("store write outside depth test or clear");

    // a covered pixel never gives a barycentric above one
    a_bary_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BEND) |-> (r_q <= QW'(BARY_ONE)))
        else $error("barycentric out of range");

    // barycentric divisions only run against a nonzero area
    a_area_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BDIV) |-> (r_aabs != '0))
        else $error("division by zero area");

    // a new result appears only out of the finish state
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_FIN))
        else $error("result raised outside finish");

endmodule
`default_nettype wire
